// File: design/bpl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpl_pkg
// Shared types and constants of the partition-tree point locator.
// ----------------------------------------------------------------------------
package bpl_pkg;

    localparam int NODES     = 4096;
    localparam int MAX_DEPTH = 64;

    localparam int NODE_AW  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int DEPTH_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int COUNT_W  = 13;
    localparam int INDEX_W  = 12;
    localparam int COORD_W  = 32;
    localparam int CHILD_W  = 16;
    localparam int SUB_W    = 15;

    // Packed input word layout, lowest field first
    localparam int S_DATA_W     = 240;
    localparam int OFS_INDEX    = 0;
    localparam int OFS_LINE_X   = 12;
    localparam int OFS_LINE_Y   = 44;
    localparam int OFS_LINE_DX  = 76;
    localparam int OFS_LINE_DY  = 108;
    localparam int OFS_FRONT    = 140;
    localparam int OFS_BACK     = 156;
    localparam int OFS_POINT_X  = 172;
    localparam int OFS_POINT_Y  = 204;

    localparam int M_DATA_W = 16;

    // Request kinds carried in s_tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // One node entry: origin, direction, links
    localparam int NODE_W = 4 * COORD_W + 2 * CHILD_W;

    // Classified item; pos_x/pos_y hold the line origin for a write and
    // the query point for a query
    typedef struct packed {
        logic                      kind;
        logic [INDEX_W-1:0]        node_index;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] line_dx;
        logic signed [COORD_W-1:0] line_dy;
        logic [CHILD_W-1:0]        child_front;
        logic [CHILD_W-1:0]        child_back;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] dy;
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
        logic [CHILD_W-1:0]        back;
        logic [CHILD_W-1:0]        front;
    } node_t;

endpackage
`default_nettype wire

// File: design/bpl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpl_front
// Accepts input words, sorts them into node writes and point queries and
// holds them in a two-entry queue for the walker.
// ----------------------------------------------------------------------------
module bpl_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [bpl_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                           s_tuser,
    output logic                                q_valid,
    output bpl_pkg::item_t                      q_item,
    input  wire logic                           q_pop
);

    bpl_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    bpl_pkg::item_t in_item;
    logic           push;
    logic           pop;

    always_comb begin
        in_item             = '0;
        in_item.kind        = s_tuser;
        in_item.node_index  = s_tdata[bpl_pkg::OFS_INDEX +: bpl_pkg::INDEX_W];
        in_item.line_dx     = s_tdata[bpl_pkg::OFS_LINE_DX +: bpl_pkg::COORD_W];
        in_item.line_dy     = s_tdata[bpl_pkg::OFS_LINE_DY +: bpl_pkg::COORD_W];
        in_item.child_front = s_tdata[bpl_pkg::OFS_FRONT +: bpl_pkg::CHILD_W];
        in_item.child_back  = s_tdata[bpl_pkg::OFS_BACK +: bpl_pkg::CHILD_W];
        // a query only needs the point; a write only the line origin
        if (s_tuser == bpl_pkg::REQ_QUERY) begin
            in_item.pos_x = s_tdata[bpl_pkg::OFS_POINT_X +: bpl_pkg::COORD_W];
            in_item.pos_y = s_tdata[bpl_pkg::OFS_POINT_Y +: bpl_pkg::COORD_W];
        end else begin
            in_item.pos_x = s_tdata[bpl_pkg::OFS_LINE_X +: bpl_pkg::COORD_W];
            in_item.pos_y = s_tdata[bpl_pkg::OFS_LINE_Y +: bpl_pkg::COORD_W];
        end
    end

    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// File: design/bpl_walker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpl_walker
// Holds the node table, applies node writes and walks the tree for queries,
// one node per pass through DIFF, MUL and PICK, with a result register toward the output.
// ----------------------------------------------------------------------------
module bpl_walker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [bpl_pkg::COUNT_W-1:0]    node_count,
    input  wire logic                           q_valid,
    input  wire bpl_pkg::item_t                 q_item,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [bpl_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                m_tuser
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIFF = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_PICK = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam int CW = bpl_pkg::COORD_W;
    localparam int PW = CW + 16;

    logic [bpl_pkg::NODE_W-1:0] node_mem [bpl_pkg::NODES];

    logic [2:0]                    state_reg, state_next;
    logic [bpl_pkg::DEPTH_W-1:0]   depth_reg, depth_next;
    logic                          m_valid_reg, m_valid_next;
    logic [bpl_pkg::SUB_W-1:0]     m_sub_reg, m_sub_next;
    logic                          m_ovf_reg, m_ovf_next;
    logic [bpl_pkg::SUB_W-1:0]     res_sub_reg, res_sub_next;
    logic                          res_ovf_reg, res_ovf_next;

    // walk datapath registers
    logic signed [CW-1:0]          px_reg, py_reg;
    bpl_pkg::node_t                rd_node_reg;
    logic                          rd_oob_reg;
    logic signed [CW-1:0]          ex_reg, ey_reg;
    logic signed [15:0]            dx_hi_reg, dy_hi_reg;
    logic                          dx_sign_reg, dy_sign_reg;
    logic                          axis_reg, axis_side_reg;
    logic [bpl_pkg::CHILD_W-1:0]   front_reg, back_reg;
    logic signed [PW-1:0]          left_p_reg, right_p_reg;
    logic                          fast_reg, fast_side_reg;

    // memory port controls
    logic                          rd_en;
    logic [bpl_pkg::NODE_AW-1:0]   rd_addr;
    logic                          rd_oob;
    logic                          wr_en;
    logic [bpl_pkg::NODE_AW-1:0]   wr_addr;
    bpl_pkg::node_t                wr_node;

    bpl_pkg::node_t                cur;
    logic signed [CW-1:0]          ex, ey;
    logic                          axis_side;
    logic                          mix_sign;
    logic signed [CW-1:0]          left_v, right_v;
    logic                          side;
    logic [bpl_pkg::CHILD_W-1:0]   child;
    logic [15:0]                   root16;
    logic [15:0]                   child16;
    logic [15:0]                   widx16;
    logic                          out_free;

    assign out_free = !m_valid_reg || m_tready;

    // side test, first stage: offsets and the axis-aligned cases
    always_comb begin
        cur = rd_oob_reg ? '0 : rd_node_reg;
        ex  = px_reg - cur.x;
        ey  = py_reg - cur.y;
        if (cur.dx == '0) begin
            axis_side = (px_reg <= cur.x) ? (cur.dy > 0) : (cur.dy < 0);
        end else begin
            axis_side = (py_reg <= cur.y) ? (cur.dx < 0) : (cur.dx > 0);
        end
    end

    assign mix_sign = dy_sign_reg ^ dx_sign_reg ^ ex_reg[CW-1] ^ ey_reg[CW-1];
    assign left_v   = left_p_reg[PW-1:16];
    assign right_v  = right_p_reg[PW-1:16];
    assign side     = fast_reg ? fast_side_reg : !(right_v < left_v);
    assign child    = side ? back_reg : front_reg;
    assign child16  = {1'b0, child[bpl_pkg::SUB_W-1:0]};

    always_comb begin
        if (32'(node_count) > bpl_pkg::NODES) begin
            root16 = 16'(bpl_pkg::NODES - 1);
        end else begin
            root16 = 16'(node_count) - 16'd1;
        end
    end

    assign widx16            = 16'(q_item.node_index);
    assign wr_addr           = widx16[bpl_pkg::NODE_AW-1:0];
    assign wr_node.x         = q_item.pos_x;
    assign wr_node.y         = q_item.pos_y;
    assign wr_node.dx        = q_item.line_dx;
    assign wr_node.dy        = q_item.line_dy;
    assign wr_node.front     = q_item.child_front;
    assign wr_node.back      = q_item.child_back;

    always_comb begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        res_sub_next = res_sub_reg;
        res_ovf_next = res_ovf_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_sub_next   = m_sub_reg;
        m_ovf_next   = m_ovf_reg;
        q_pop        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = root16[bpl_pkg::NODE_AW-1:0];
        rd_oob       = 1'b0;
        wr_en        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_item.kind == bpl_pkg::REQ_WRITE) begin
                        wr_en = (32'(q_item.node_index) < bpl_pkg::NODES);
                    end else if (node_count == '0) begin
                        res_sub_next = '0;
                        res_ovf_next = 1'b0;
                        state_next   = ST_DONE;
                    end else begin
                        rd_en      = 1'b1;
                        depth_next = '0;
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_DIFF: state_next = ST_MUL;
            ST_MUL:  state_next = ST_PICK;
            ST_PICK: begin
                if (child[bpl_pkg::CHILD_W-1]) begin
                    res_sub_next = child[bpl_pkg::SUB_W-1:0];
                    res_ovf_next = 1'b0;
                    state_next   = ST_DONE;
                end else if (32'(depth_reg) == bpl_pkg::MAX_DEPTH - 1) begin
                    res_sub_next = '0;
                    res_ovf_next = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    // fetch the child node; an index past the table reads as zero
                    rd_en      = 1'b1;
                    rd_addr    = child16[bpl_pkg::NODE_AW-1:0];
                    rd_oob     = (32'(child[bpl_pkg::SUB_W-1:0]) >= bpl_pkg::NODES);
                    depth_next = depth_reg + 1'b1;
                    state_next = ST_DIFF;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_sub_next   = res_sub_reg;
                    m_ovf_next   = res_ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        depth_reg   <= depth_next;
        res_sub_reg <= res_sub_next;
        res_ovf_reg <= res_ovf_next;
        m_sub_reg   <= m_sub_next;
        m_ovf_reg   <= m_ovf_next;
        if (state_reg == ST_IDLE) begin
            px_reg <= q_item.pos_x;
            py_reg <= q_item.pos_y;
        end
        // first stage of the side test
        ex_reg        <= ex;
        ey_reg        <= ey;
        dx_hi_reg     <= cur.dx[CW-1:16];
        dy_hi_reg     <= cur.dy[CW-1:16];
        dx_sign_reg   <= cur.dx[CW-1];
        dy_sign_reg   <= cur.dy[CW-1];
        axis_reg      <= (cur.dx == '0) || (cur.dy == '0);
        axis_side_reg <= axis_side;
        front_reg     <= cur.front;
        back_reg      <= cur.back;
        // second stage: products and the sign shortcut
        left_p_reg    <= PW'(dy_hi_reg) * PW'(ex_reg);
        right_p_reg   <= PW'(dx_hi_reg) * PW'(ey_reg);
        fast_reg      <= axis_reg || mix_sign;
        fast_side_reg <= axis_reg ? axis_side_reg : (dy_sign_reg ^ ex_reg[CW-1]);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[wr_addr] <= wr_node;
        end
        if (rd_en) begin
            rd_node_reg <= node_mem[rd_addr];
            rd_oob_reg  <= rd_oob;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_sub_reg};
    assign m_tuser  = m_ovf_reg;

endmodule
`default_nettype wire

// File: design/bsp_point_location_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: a node write is applied as it is popped from the queue; a query passes each
//   visited node through the side test before the result reaches the output register,
//   and an empty tree goes straight to it. One word is in the walk at a time; the side
//   test per node (node memory read, offset, product compare) sets the rate.
// Reset: synchronous, active low; clears the queue, walker, output and node count.
//   The node table is not cleared and holds no data until written.
// ----------------------------------------------------------------------------
// bsp_point_location_unit
// Partition-tree point locator: node table loading and point queries.
// ----------------------------------------------------------------------------
module bsp_point_location_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [bpl_pkg::COUNT_W-1:0]    cfg_wr_data,  // node_count
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // node_index, line_x, line_y, line_dx, line_dy, child_front, child_back,
    // point_x, point_y, zero fill
    input  wire logic [bpl_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                           s_tuser,      // req_type
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [bpl_pkg::M_DATA_W-1:0]        m_tdata,      // subsector_index, zero fill
    output logic                                m_tuser       // walk_overflow
);

    logic [bpl_pkg::COUNT_W-1:0] node_count_reg;
    logic                        q_valid;
    logic                        q_pop;
    bpl_pkg::item_t              q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= '0;
        end else if (cfg_wr_en) begin
            node_count_reg <= cfg_wr_data;
        end
    end

    bpl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    bpl_walker u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .node_count (node_count_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
`default_nettype wire
